// ----- rtl/spur_pkg.sv -----
// Shared constants and types for the scan point uniform resampler.
// No dependencies.
package spur_pkg;

   localparam int MAX_RUN = 64;
   localparam int CNT_W   = $clog2(MAX_RUN + 1);

   localparam logic [23:0] MIN_SPACING_RST = 24'd3277;
   localparam logic [23:0] GAP_LIMIT_RST   = 24'd16384;

   localparam logic REG_MIN_SPACING = 1'b0;
   localparam logic REG_GAP_LIMIT   = 1'b1;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic        interp;
   } point_type;

endpackage

// ----- rtl/scan_point_uniform_resampler.sv -----
// Top level of the scan point uniform resampler: sequencer around one shared
// multiplier and one shared subtractor (square root and division).
// Depends on spur_pkg.

// A point marked scan_start is taken and passed through.
// Any other point runs segment tests (difference, two squares on the
// shared 32x32 multiplier, then a 33 step bit-serial square root) and, for
// each interpolated point, two 33 step divisions on the shared subtractor.
// The block takes no new beat until every result of the current point has
// gone to the output register, and stalls while that register and the one
// held-back result are both full.
module scan_point_uniform_resampler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] point_x, [63:32] point_y
   input  logic        req_tuser,   // [0] scan_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] out_x, [63:32] out_y
   output logic [1:0]  rsp_tuser,   // [0] is_interpolated, [1] run_overflow
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      IDLE, DIFF, MUL_X, MUL_Y, SUM, SQRT, DECIDE,
      MUL_D, DIV_INIT, DIV, DIV_DONE, PUSH, FLUSH
   } state_type;

   state_type state_ff;

   logic [23:0] min_sp_ff, gap_ff;
   logic [31:0] cx_ff, cy_ff, px_ff, py_ff;
   logic [23:0] acc_ff;
   logic [31:0] ax_ff, ay_ff;
   logic        dxneg_ff, dyneg_ff, sel_y_ff;
   logic [63:0] prod_ff;
   logic [65:0] rad_ff;
   logic [35:0] rem_ff;
   logic [32:0] root_ff, len_ff;
   logic [5:0]  it_ff;
   logic [23:0] num_ff;
   logic [spur_pkg::CNT_W-1:0] cnt_ff;
   logic        raw_ff, ovf_ff;
   spur_pkg::point_type nr_ff, pend_ff, rsp_ff;
   logic        pend_valid_ff, rsp_valid_ff, rsp_last_ff, rsp_ovf_ff;

   // configuration
   logic cfg_wr;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         spur_pkg::REG_MIN_SPACING: csr_prdata = {8'b0, min_sp_ff};
         default:                   csr_prdata = {8'b0, gap_ff};
      endcase
   end

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   always_comb begin
      unique case (state_ff)
         MUL_X:   begin mul_a = ax_ff; mul_b = ax_ff; end
         MUL_Y:   begin mul_a = ay_ff; mul_b = ay_ff; end
         default: begin
            mul_a = sel_y_ff ? ay_ff : ax_ff;
            mul_b = {8'b0, num_ff};
         end
      endcase
   end
   logic [63:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // shared subtractor: square root step or division step
   logic [35:0] sub_a, sub_b;
   logic [36:0] sub_d;
   logic        sub_ge;
   always_comb begin
      if (state_ff == SQRT) begin
         sub_a = {rem_ff[33:0], rad_ff[65:64]};
         sub_b = {1'b0, root_ff, 2'b01};
      end else begin
         sub_a = {rem_ff[34:0], rad_ff[65]};
         sub_b = {3'b0, len_ff};
      end
   end
   assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge = !sub_d[36];

   logic [32:0] dx_w, dy_w;
   assign dx_w = {cx_ff[31], cx_ff} - {px_ff[31], px_ff};
   assign dy_w = {cy_ff[31], cy_ff} - {py_ff[31], py_ff};

   logic [33:0] sum_w;
   assign sum_w = {10'b0, acc_ff} + {1'b0, root_ff};

   logic [56:0] n_w;
   assign n_w = {1'b0, prod_ff[55:0]} + {25'b0, len_ff[32:1]};

   logic [31:0] base_w;
   logic        neg_w;
   logic [33:0] res_w;
   assign base_w = sel_y_ff ? py_ff : px_ff;
   assign neg_w  = sel_y_ff ? dyneg_ff : dxneg_ff;
   assign res_w  = neg_w ? {{2{base_w[31]}}, base_w} - {1'b0, root_ff}
                         : {{2{base_w[31]}}, base_w} + {1'b0, root_ff};

   logic slot_free;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   logic push_go, rsp_load;
   assign push_go  = slot_free || !pend_valid_ff;
   assign rsp_load = pend_valid_ff && slot_free && (state_ff == PUSH || state_ff == FLUSH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         min_sp_ff     <= spur_pkg::MIN_SPACING_RST;
         gap_ff        <= spur_pkg::GAP_LIMIT_RST;
         px_ff         <= '0;
         py_ff         <= '0;
         acc_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         sel_y_ff      <= 1'b0;
      end else begin
         if (cfg_wr) begin
            unique case (csr_paddr[2])
               spur_pkg::REG_MIN_SPACING: min_sp_ff <= csr_pwdata[23:0];
               default:                   gap_ff    <= csr_pwdata[23:0];
            endcase
         end
         if (rsp_tready && !rsp_load) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            IDLE: begin
               if (req_tvalid) begin
                  cx_ff  <= req_tdata[31:0];
                  cy_ff  <= req_tdata[63:32];
                  cnt_ff <= '0;
                  ovf_ff <= 1'b0;
                  if (req_tuser) begin
                     pend_ff       <= '{x: req_tdata[31:0], y: req_tdata[63:32], interp: 1'b0};
                     pend_valid_ff <= 1'b1;
                     px_ff         <= req_tdata[31:0];
                     py_ff         <= req_tdata[63:32];
                     acc_ff        <= '0;
                     state_ff      <= FLUSH;
                  end else begin
                     state_ff <= DIFF;
                  end
               end
            end
            DIFF: begin
               dxneg_ff <= dx_w[32];
               dyneg_ff <= dy_w[32];
               ax_ff    <= dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
               ay_ff    <= dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
               state_ff <= MUL_X;
            end
            MUL_X: begin
               prod_ff  <= mul_p;
               state_ff <= MUL_Y;
            end
            MUL_Y: begin
               rad_ff   <= {2'b0, prod_ff};
               prod_ff  <= mul_p;
               state_ff <= SUM;
            end
            SUM: begin
               rad_ff   <= rad_ff + {2'b0, prod_ff};
               rem_ff   <= '0;
               root_ff  <= '0;
               it_ff    <= 6'd32;
               state_ff <= SQRT;
            end
            SQRT: begin
               rem_ff  <= sub_ge ? sub_d[35:0] : sub_a;
               root_ff <= {root_ff[31:0], sub_ge};
               rad_ff  <= {rad_ff[63:0], 2'b00};
               it_ff   <= it_ff - 6'd1;
               if (it_ff == 6'd0) state_ff <= DECIDE;
            end
            DECIDE: begin
               len_ff <= root_ff;
               num_ff <= (min_sp_ff > acc_ff) ? min_sp_ff - acc_ff : 24'd0;
               if (sum_w < {10'b0, min_sp_ff}) begin
                  acc_ff   <= sum_w[23:0];
                  px_ff    <= cx_ff;
                  py_ff    <= cy_ff;
                  state_ff <= FLUSH;
               end else if (cnt_ff >= spur_pkg::CNT_W'(spur_pkg::MAX_RUN)) begin
                  acc_ff   <= '0;
                  px_ff    <= cx_ff;
                  py_ff    <= cy_ff;
                  ovf_ff   <= 1'b1;
                  state_ff <= FLUSH;
               end else if (sum_w >= {10'b0, gap_ff}) begin
                  acc_ff   <= '0;
                  px_ff    <= cx_ff;
                  py_ff    <= cy_ff;
                  nr_ff    <= '{x: cx_ff, y: cy_ff, interp: 1'b0};
                  raw_ff   <= 1'b1;
                  state_ff <= PUSH;
               end else if (root_ff == '0) begin
                  acc_ff   <= '0;
                  nr_ff    <= '{x: px_ff, y: py_ff, interp: 1'b1};
                  raw_ff   <= 1'b0;
                  state_ff <= PUSH;
               end else begin
                  sel_y_ff <= 1'b0;
                  state_ff <= MUL_D;
               end
            end
            MUL_D: begin
               prod_ff  <= mul_p;
               state_ff <= DIV_INIT;
            end
            DIV_INIT: begin
               rem_ff   <= {12'b0, n_w[56:33]};
               rad_ff   <= {n_w[32:0], 33'b0};
               root_ff  <= '0;
               it_ff    <= 6'd32;
               state_ff <= DIV;
            end
            DIV: begin
               rem_ff  <= sub_ge ? sub_d[35:0] : sub_a;
               root_ff <= {root_ff[31:0], sub_ge};
               rad_ff  <= {rad_ff[64:0], 1'b0};
               it_ff   <= it_ff - 6'd1;
               if (it_ff == 6'd0) state_ff <= DIV_DONE;
            end
            DIV_DONE: begin
               if (!sel_y_ff) begin
                  nr_ff.x  <= res_w[31:0];
                  sel_y_ff <= 1'b1;
                  state_ff <= MUL_D;
               end else begin
                  nr_ff.y      <= res_w[31:0];
                  nr_ff.interp <= 1'b1;
                  px_ff        <= nr_ff.x;
                  py_ff        <= res_w[31:0];
                  acc_ff       <= '0;
                  raw_ff       <= 1'b0;
                  sel_y_ff     <= 1'b0;
                  state_ff     <= PUSH;
               end
            end
            PUSH: begin
               if (push_go) begin
                  if (pend_valid_ff) begin
                     rsp_ff       <= pend_ff;
                     rsp_last_ff  <= 1'b0;
                     rsp_ovf_ff   <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                  end
                  pend_ff       <= nr_ff;
                  pend_valid_ff <= 1'b1;
                  cnt_ff        <= cnt_ff + 1'b1;
                  state_ff      <= raw_ff ? FLUSH : DIFF;
               end
            end
            FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= IDLE;
               end else if (slot_free) begin
                  rsp_ff        <= pend_ff;
                  rsp_last_ff   <= 1'b1;
                  rsp_ovf_ff    <= ovf_ff;
                  rsp_valid_ff  <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.y, rsp_ff.x};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_ff.interp};
   assign rsp_tlast  = rsp_last_ff;

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == IDLE |-> !pend_valid_ff) else $error("held result in idle");
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_last_ff) else $error("overflow not last");
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= spur_pkg::CNT_W'(spur_pkg::MAX_RUN)) else $error("run count past cap");
   a_acc_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == SQRT |=> $stable(acc_ff)) else $error("distance moved in root");

endmodule

// ----- bench/tb.sv -----
// Testbench for scan_point_uniform_resampler: predicts each emitted point from
// a bit-accurate model of the resampling and checks the output stream.
// Depends on spur_pkg and the resampler RTL.
`timescale 1ns / 100ps

class resample_scoreboard;
   logic [31:0] spacing;
   logic [31:0] gap;
   longint      prev_x;
   longint      prev_y;
   longint unsigned acc_dist;
   spur_pkg::point_type pending_pt[$];
   logic pending_last[$];
   logic pending_ovf[$];
   int mismatches;

   function new();
      spacing = spur_pkg::MIN_SPACING_RST;
      gap = spur_pkg::GAP_LIMIT_RST;
      prev_x = 0;
      prev_y = 0;
      acc_dist = 0;
      mismatches = 0;
   endfunction

   function automatic longint unsigned isqrt(longint dx, longint dy);
      logic [65:0] s;
      logic [67:0] c2;
      logic [33:0] r;
      logic [33:0] c;
      longint unsigned ax;
      longint unsigned ay;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      s = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      r = 0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (34'd1 << b);
         c2 = 68'(c) * 68'(c);
         if (c2 <= 68'(s)) r = c;
      end
      return longint'(r);
   endfunction

   function automatic longint step_off(longint d, longint unsigned num,
                                       longint unsigned len);
      logic [95:0] q;
      longint unsigned ad;
      if (len == 0) return 0;
      ad = d < 0 ? -d : d;
      q = (96'(ad) * 96'(num) + 96'(len / 2)) / 96'(len);
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic void push(longint x, longint y, logic interp);
      spur_pkg::point_type p;
      p.x = x[31:0];
      p.y = y[31:0];
      p.interp = interp;
      pending_pt.push_back(p);
      pending_last.push_back(1'b0);
      pending_ovf.push_back(1'b0);
   endfunction

   function void note_point(logic [31:0] px, logic [31:0] py, logic start);
      longint cx;
      longint cy;
      longint dx;
      longint dy;
      longint unsigned len;
      longint unsigned sum;
      longint unsigned num;
      longint nx;
      longint ny;
      int count;
      cx = longint'(signed'(px));
      cy = longint'(signed'(py));
      count = 0;
      if (start) begin
         push(cx, cy, 1'b0);
         pending_last[$] = 1'b1;
         prev_x = cx;
         prev_y = cy;
         acc_dist = 0;
         return;
      end
      forever begin
         dx = cx - prev_x;
         dy = cy - prev_y;
         len = isqrt(dx, dy);
         sum = acc_dist + len;
         if (sum < spacing) begin
            acc_dist = sum;
            prev_x = cx;
            prev_y = cy;
            break;
         end
         if (count >= spur_pkg::MAX_RUN) begin
            pending_ovf[$] = 1'b1;
            prev_x = cx;
            prev_y = cy;
            acc_dist = 0;
            break;
         end
         if (sum >= gap) begin
            push(cx, cy, 1'b0);
            count++;
            prev_x = cx;
            prev_y = cy;
            acc_dist = 0;
            break;
         end
         num = spacing > acc_dist ? spacing - acc_dist : 0;
         nx = prev_x + step_off(dx, num, len);
         ny = prev_y + step_off(dy, num, len);
         push(nx, ny, 1'b1);
         count++;
         prev_x = nx;
         prev_y = ny;
         acc_dist = 0;
      end
      if (count > 0) pending_last[$] = 1'b1;
   endfunction

   function void check_beat(logic [63:0] data, logic [1:0] user, logic last);
      spur_pkg::point_type p;
      logic el;
      logic eo;
      if (pending_pt.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected beat x=%h y=%h", data[31:0], data[63:32]);
         return;
      end
      p = pending_pt.pop_front();
      el = pending_last.pop_front();
      eo = pending_ovf.pop_front();
      if (data[31:0] !== p.x || data[63:32] !== p.y || user[0] !== p.interp ||
          user[1] !== eo || last !== el) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h i=%b o=%b l=%b got x=%h y=%h i=%b o=%b l=%b",
                     p.x, p.y, p.interp, eo, el, data[31:0], data[63:32], user[0],
                     user[1], last);
      end
   endfunction
endclass

module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] point_x, [63:32] point_y
   logic        req_tuser = 1'b0; // [0] scan_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [31:0] out_x, [63:32] out_y
   logic [1:0]  rsp_tuser;        // [0] is_interpolated, [1] run_overflow
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   resample_scoreboard sb;
   int  send_idle = 0;
   int  recv_stall = 0;
   int  quiet_cycles = 0;
   logic [31:0] cur_x = 0;
   logic [31:0] cur_y = 0;

   localparam int WATCHDOG = 200000;

   scan_point_uniform_resampler u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= recv_stall);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic write_reg(logic regsel, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {regsel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (regsel == spur_pkg::REG_MIN_SPACING) sb.spacing = value & 32'hFFFFFF;
      else sb.gap = value & 32'hFFFFFF;
   endtask

   task automatic send_point(logic [31:0] px, logic [31:0] py, logic start);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {py, px};
      req_tuser <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_point(px, py, start);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_pt.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic random_scan(int n, int step);
      logic [31:0] sx;
      logic [31:0] sy;
      for (int i = 0; i < n; i++) begin
         if (i == 0 || $urandom_range(30) == 0) begin
            cur_x = $urandom;
            cur_y = $urandom;
            send_point(cur_x, cur_y, 1'b1);
         end else if ($urandom_range(15) == 0) begin
            send_point($urandom, $urandom, 1'($urandom_range(1)));
         end else begin
            sx = $urandom_range(2 * step) - step;
            sy = $urandom_range(2 * step) - step;
            cur_x = cur_x + sx;
            cur_y = cur_y + sy;
            send_point(cur_x, cur_y, 1'b0);
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // directed: defaults, extremes, first point without scan start
      send_point(32'd5000, 32'd0, 1'b0);
      send_point(32'h7FFFFFFF, 32'h80000000, 1'b1);
      send_point(32'h80000000, 32'h7FFFFFFF, 1'b0);
      send_point(32'd0, 32'd0, 1'b1);
      send_point(32'd0, 32'd0, 1'b0);
      send_point(32'd1000, 32'd0, 1'b0);
      send_point(32'd9000, 32'd3000, 1'b0);
      send_point(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
      drain();
      write_reg(spur_pkg::REG_MIN_SPACING, 32'd1);
      write_reg(spur_pkg::REG_GAP_LIMIT, 32'hFFFFFF);
      send_point(32'd0, 32'd0, 1'b1);
      send_point(32'd200, 32'd0, 1'b0);
      send_point(32'd200, 32'd0, 1'b0);
      drain();
      write_reg(spur_pkg::REG_MIN_SPACING, 32'd60000);
      send_point(32'd0, 32'd0, 1'b1);
      send_point(32'd40000, 32'd0, 1'b0);
      drain();
      // spacing below accumulated distance
      write_reg(spur_pkg::REG_MIN_SPACING, 32'd100);
      send_point(32'd40050, 32'd0, 1'b0);
      send_point(32'd40050, 32'd0, 1'b0);
      drain();
      write_reg(spur_pkg::REG_MIN_SPACING, 32'hFFFFFF);
      write_reg(spur_pkg::REG_GAP_LIMIT, 32'd1);
      send_point(32'd0, 32'd0, 1'b1);
      send_point(32'h01000000, 32'd0, 1'b0);
      send_point(32'h00000005, 32'd0, 1'b0);
      drain();
      // random phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 80; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 80; end
            default: begin send_idle = 22; recv_stall = 22; end
         endcase
         write_reg(spur_pkg::REG_MIN_SPACING, $urandom_range(2000, 8000));
         write_reg(spur_pkg::REG_GAP_LIMIT, $urandom_range(20000, 60000));
         random_scan(60, 10000);
         drain();
         write_reg(spur_pkg::REG_MIN_SPACING, 32'hFFFFFF);
         write_reg(spur_pkg::REG_MIN_SPACING, $urandom_range(1, 16777215));
         write_reg(spur_pkg::REG_GAP_LIMIT, $urandom_range(1, 16777215));
         random_scan(60, 10000000);
         drain();
      end
      while (sb.pending_pt.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_pt.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
